>>> hdl/table_linear_interpolator_core_assert.svh
// Assertion macros for the table linear interpolator.
// Included by the top level; no other dependencies.
`ifndef TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
// implication checked each clock, quiet in reset
`define TLI_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define TLI_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> hdl/tli_pkg.sv
// Package for the table linear interpolator: payload structs, constants, state enum.
// No dependencies.
`default_nettype none
package tli_pkg;
  localparam int TableDepthDefault = 1024;
  localparam int QueueDepth = 2;
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic        func;
    logic [9:0]  entry_index;
    logic signed [31:0] entry_time;
    logic signed [31:0] entry_offset;
    logic signed [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] offset_value;
    logic        held_last;
    logic        zero_span;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_RD, S_WAIT, S_CMP, S_PREV, S_PWAIT, S_MUL, S_DSTART, S_DIV, S_FIN,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

>>> hdl/tli_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module tli_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> hdl/tli_queue.sv
// Small FIFO between front and back parts.
// Depends on tli_pkg.
`default_nettype none
module tli_queue import tli_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output in_item_t      out_data
);
  in_item_t slots [QueueDepth];
  logic     wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;
  assign in_ready  = (count != 2'(QueueDepth));
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

>>> hdl/tli_divider.sv
// Unsigned 64/33 restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module tli_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [32:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] quo;
  logic [33:0] rem;
  logic [32:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic [33:0] shifted;
  assign shifted = {rem[32:0], quo[63]};
  assign trial   = shifted - {1'b0, dvs};
  assign quotient = quo;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/tli_engine.sv
// Back part: table storage, sequential walk, multiply and divide, output register.
// Depends on tli_pkg, tli_ram, tli_divider.
`default_nettype none
module tli_engine import tli_pkg::*; #(
  parameter int TableDepth = TableDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [10:0] entries_in_use,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire in_item_t    item,
  output logic             res_valid,
  input  wire logic        res_ready,
  output out_item_t        res
);
  localparam int AW = $clog2(TableDepth);
  localparam int CW = AW + 1;

  state_t state, state_next;
  in_item_t cur;
  logic [CW-1:0] n_eff, idx;
  logic [AW-1:0] addr;
  logic we;
  logic [31:0] t_rd, o_rd;
  logic signed [31:0] t2, o2, t1, o1;
  logic signed [32:0] den, a, b;
  logic [63:0] prod;
  logic neg;
  logic div_start, div_done;
  logic [63:0] quot;
  logic [63:0] quot_sat;
  logic signed [35:0] sq, r;
  logic [CW-1:0] entries_clip;

  tli_ram #(.Width(32), .Depth(TableDepth)) u_times (
    .clk(clk), .we(we), .addr(addr), .wdata(cur.entry_time), .rdata(t_rd));
  tli_ram #(.Width(32), .Depth(TableDepth)) u_offsets (
    .clk(clk), .we(we), .addr(addr), .wdata(cur.entry_offset), .rdata(o_rd));

  tli_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(prod), .divisor(den[32] ? 33'(-den) : 33'(den)),
    .done(div_done), .quotient(quot));

  // effective entry count, clipped into [1, TableDepth]
  always_comb begin
    if (entries_in_use == 11'd0) begin
      entries_clip = CW'(1);
    end else if (32'(entries_in_use) > 32'(TableDepth)) begin
      entries_clip = CW'(TableDepth);
    end else begin
      entries_clip = CW'(entries_in_use);
    end
  end

  // span terms; operands hold still from the multiply to the end of the item
  assign den = 33'(t2) - 33'(t1);
  assign a   = 33'(cur.query_time) - 33'(t1);
  assign b   = 33'(o2) - 33'(o1);

  assign quot_sat = (quot > 64'h4_0000_0000) ? 64'h4_0000_0000 : quot;
  assign sq = neg ? -36'(quot_sat[34:0]) : 36'(quot_sat[34:0]);
  assign r  = sq + 36'(o1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (item_valid) state_next = (item.func == FUNC_WRITE) ? S_WRITE : S_RD;
      S_WRITE: state_next = S_IDLE;
      S_RD:    state_next = S_WAIT;
      S_WAIT:  state_next = S_CMP;
      S_CMP: begin
        if ($signed(t_rd) >= cur.query_time) begin
          state_next = (idx == '0) ? S_MUL : S_PREV;
        end else if (idx == n_eff - CW'(1)) begin
          state_next = S_OUT;
        end else begin
          state_next = S_RD;
        end
      end
      S_PREV:   state_next = S_PWAIT;
      S_PWAIT:  state_next = S_MUL;
      S_MUL:    state_next = (t2 == t1) ? S_OUT : S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV:    if (div_done) state_next = S_FIN;
      S_FIN:    state_next = S_OUT;
      S_OUT:    if (res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state == S_IDLE);
    we = (state == S_WRITE) && (32'(cur.entry_index) < 32'(TableDepth));
    addr = (state == S_PREV) ? AW'(idx - CW'(1))
         : (state == S_WRITE) ? AW'(cur.entry_index) : AW'(idx);
    res_valid = (state == S_OUT);
    div_start = (state == S_DSTART);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur <= item;
        idx <= '0;
        n_eff <= entries_clip;
        t1 <= '0;
        o1 <= '0;
      end
      S_CMP: begin
        t2 <= $signed(t_rd);
        o2 <= $signed(o_rd);
        if ($signed(t_rd) < cur.query_time) begin
          if (idx == n_eff - CW'(1)) begin
            res.offset_value <= $signed(o_rd);
            res.held_last <= 1'b1;
            res.zero_span <= 1'b0;
          end else begin
            idx <= idx + CW'(1);
          end
        end
      end
      S_PWAIT: begin
        t1 <= $signed(t_rd);
        o1 <= $signed(o_rd);
      end
      S_MUL: begin
        neg <= (a[32] ^ b[32]) ^ den[32];
        prod <= 64'(a[32] ? 33'(-a) : a) * 64'(b[32] ? 33'(-b) : b);
        res.offset_value <= o2;
        res.held_last <= 1'b0;
        res.zero_span <= (t2 == t1);
      end
      S_FIN: begin
        if (r > 36'sd2147483647) res.offset_value <= 32'h7fff_ffff;
        else if (r < -36'sd2147483648) res.offset_value <= 32'h8000_0000;
        else res.offset_value <= r[31:0];
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/table_linear_interpolator_core.sv
// Top level of the table linear interpolator: config register, front queue, engine.
// Depends on tli_pkg, tli_queue, tli_engine and the assertion header.
//
// Usage:
//  - in_valid/in_ready carry one transaction: func 0 writes a breakpoint
//    (entry_index, entry_time, entry_offset), func 1 asks a query at query_time.
//  - out_valid/out_ready return one result transaction per query; writes give none.
//  - cfg_we/cfg_data set entries_in_use (reset 1); the user sets it only while idle, the block does not enforce this.
//  - A two-deep queue takes transactions while the engine works.
//  - Write: passes the queue and engine idle, then the table write state.
//    Query: each table entry walked passes read, wait and compare states; a span
//    found past the first entry reads the previous one, then it multiplies, runs
//    the 64-step divider and finishes; a held or zero-span result skips the divider.
//    The walk is sequential, as both tables share a single address port.
//  - The result waits in the engine's output register while out_ready is low;
//    the queue keeps taking input until full.
//  - Synchronous reset clears control only; table contents are undefined
//    until written, and no clearing pass runs.
`default_nettype none
`include "table_linear_interpolator_core_assert.svh"
module table_linear_interpolator_core import tli_pkg::*; #(
  parameter int TableDepth = TableDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_data
);
  logic [10:0] entries_in_use;
  logic        q_valid, q_ready;
  in_item_t    q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= 11'd1;
    end else if (cfg_we) begin
      entries_in_use <= cfg_data;
    end
  end

  tli_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data));

  tli_engine #(.TableDepth(TableDepth)) u_engine (
    .clk(clk), .rst(rst), .entries_in_use(entries_in_use),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_data),
    .res_valid(out_valid), .res_ready(out_ready), .res(out_data));

  // a result never claims both held and zero span
  `TLI_ASSERT_IMP(a_flags_excl, clk, rst, out_valid, !(out_data.held_last && out_data.zero_span), "both flags set")
  // a stalled result stays put
  `TLI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
endmodule
`default_nettype wire
